/* rtl/alc_pkg.sv */
// types, constants and codes shared by the list-with-cursor block
package alc_pkg;

  parameter int ALC_CAPACITY   = 64;
  parameter int ALC_DATA_WIDTH = 32;
  parameter int ACT_W          = 4;
  parameter int ST_W           = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 4'd0,
    ACT_APPEND = 4'd1,
    ACT_ERASE  = 4'd2,
    ACT_BEGIN  = 4'd3,
    ACT_END    = 4'd4,
    ACT_PREV   = 4'd5,
    ACT_NEXT   = 4'd6,
    ACT_SETPOS = 4'd7,
    ACT_FIND   = 4'd8,
    ACT_CLEAR  = 4'd9
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    UPD_NONE = 2'd0,
    UPD_INS  = 2'd1,
    UPD_WR   = 2'd2,
    UPD_DEL  = 2'd3
  } upd_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_e;

  typedef struct packed {
    upd_e kind;
    logic find_en;
  } alc_ctrl_t;

  typedef struct packed {
    logic active;
    logic found;
  } probe_t;

endpackage

/* rtl/alc_cell.sv */
// one list entry: shifts with its neighbors and passes the scan probe along
module alc_cell #(
  parameter int DATA_WIDTH = alc_pkg::ALC_DATA_WIDTH,
  parameter int CNT_W      = 7,
  parameter int IDX_W      = 6,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  alc_pkg::alc_ctrl_t    ctrl_i,
  input  logic [CNT_W-1:0]      upd_at_i,
  input  logic [DATA_WIDTH-1:0] upd_val_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] key_i,
  input  logic [CNT_W-1:0]      rd_pos_i,
  input  logic [CNT_W-1:0]      cnt_i,
  input  alc_pkg::probe_t       probe_i,
  input  logic [DATA_WIDTH-1:0] probe_val_i,
  input  logic [IDX_W-1:0]      probe_idx_i,
  output logic [DATA_WIDTH-1:0] entry_o,
  output alc_pkg::probe_t       probe_o,
  output logic [DATA_WIDTH-1:0] probe_val_o,
  output logic [IDX_W-1:0]      probe_idx_o
);
  import alc_pkg::*;

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] entry_q;
  probe_t                probe_q;
  logic [DATA_WIDTH-1:0] pval_q;
  logic [IDX_W-1:0]      pidx_q;
  logic                  hit;

  assign hit = ctrl_i.find_en && probe_i.active && !probe_i.found &&
               (MY_POS < cnt_i) && (entry_q == key_i);

  always_ff @(posedge clk_i) begin
    case (ctrl_i.kind)
      UPD_INS: begin
        if (MY_POS > upd_at_i) begin
          entry_q <= left_i;
        end else if (MY_POS == upd_at_i) begin
          entry_q <= upd_val_i;
        end
      end
      UPD_WR: begin
        if (MY_POS == upd_at_i) begin
          entry_q <= upd_val_i;
        end
      end
      UPD_DEL: begin
        if (MY_POS >= upd_at_i) begin
          entry_q <= right_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q.active <= probe_i.active;
      probe_q.found  <= probe_i.found | hit;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= hit ? MY_IDX : probe_idx_i;
    pval_q <= (MY_POS == rd_pos_i) ? entry_q : probe_val_i;
  end

  assign entry_o     = entry_q;
  assign probe_o     = probe_q;
  assign probe_val_o = pval_q;
  assign probe_idx_o = pidx_q;

endmodule

/* rtl/array_list_with_cursor.sv */
// top level: request decode, cursor and size control, and the row of entry cells
// a request is registered at accept; its result waits for the probe that walks the cells, then is registered at commit
// a new request is taken only in idle, so one request is in flight at a time
// a result not yet taken holds the current request at commit, and the input stays closed until it commits
// reset: size and cursor go to 0; entry contents stay undefined until written
module array_list_with_cursor #(
  parameter int CAPACITY   = alc_pkg::ALC_CAPACITY,
  parameter int DATA_WIDTH = alc_pkg::ALC_DATA_WIDTH,
  localparam int CNT_W  = $clog2(CAPACITY + 1),
  localparam int IDX_W  = $clog2(CAPACITY),
  localparam int IN_W   = alc_pkg::ACT_W + DATA_WIDTH + CNT_W,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = DATA_WIDTH + 2 * CNT_W + 1 + IDX_W + alc_pkg::ST_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // action, item_value, target_position
  input  logic [IN_TW-1:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // current_value, list_size, cursor, found, found_index, status
  output logic [OUT_TW-1:0] m_axis_tdata
);
  import alc_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  state_e state_q, state_d;

  logic [CNT_W-1:0]      count_q, cursor_q;
  logic [CNT_W-1:0]      cnt_nx_q, cur_nx_q;
  status_e               st_q;
  upd_e                  kind_q;
  logic [CNT_W-1:0]      at_q;
  logic                  find_q, ovr_q, rd_en_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic                  start_q;
  logic                  res_found_q;
  logic [IDX_W-1:0]      res_idx_q;
  logic [DATA_WIDTH-1:0] res_val_q;

  logic                  m_tvalid_q;
  logic [DATA_WIDTH-1:0] out_val_q;
  logic [CNT_W-1:0]      out_size_q, out_cur_q;
  logic                  out_found_q;
  logic [IDX_W-1:0]      out_idx_q;
  status_e               out_st_q;

  action_e               act;
  logic [DATA_WIDTH-1:0] in_val;
  logic [CNT_W-1:0]      in_target;
  logic [CNT_W-1:0]      cnt_d, cur_d, at_d;
  status_e               st_d;
  upd_e                  kind_d;
  logic                  ovr_d, erase_ok_d, find_d, rd_en_d;
  logic                  accept, commit;

  alc_ctrl_t             ctrl;
  logic [DATA_WIDTH-1:0] entry  [CAPACITY];
  logic [DATA_WIDTH-1:0] left_w [CAPACITY];
  logic [DATA_WIDTH-1:0] right_w[CAPACITY];
  probe_t                probe  [CAPACITY+1];
  logic [DATA_WIDTH-1:0] pval   [CAPACITY+1];
  logic [IDX_W-1:0]      pidx   [CAPACITY+1];

  assign act       = action_e'(s_axis_tdata[ACT_W-1:0]);
  assign in_val    = s_axis_tdata[ACT_W +: DATA_WIDTH];
  assign in_target = s_axis_tdata[ACT_W + DATA_WIDTH +: CNT_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == S_DONE) && (!m_tvalid_q || m_axis_tready);

  // request decode against the current size and cursor
  always_comb begin
    cnt_d      = count_q;
    cur_d      = cursor_q;
    st_d       = ST_OK;
    kind_d     = UPD_NONE;
    at_d       = cursor_q;
    ovr_d      = 1'b0;
    erase_ok_d = 1'b0;
    find_d     = 1'b0;
    unique case (act)
      ACT_INSERT: begin
        if (count_q == CAP_CNT) begin
          st_d = ST_FULL;
        end else begin
          cnt_d  = count_q + ONE;
          kind_d = UPD_INS;
          ovr_d  = 1'b1;
        end
      end
      ACT_APPEND: begin
        if (count_q == CAP_CNT) begin
          st_d = ST_FULL;
        end else begin
          cnt_d  = count_q + ONE;
          kind_d = UPD_WR;
          at_d   = count_q;
          ovr_d  = (cursor_q == count_q);
        end
      end
      ACT_ERASE: begin
        if (count_q == '0) begin
          st_d = ST_EMPTY;
        end else if (cursor_q >= count_q) begin
          st_d = ST_RANGE;
        end else begin
          cnt_d      = count_q - ONE;
          kind_d     = UPD_DEL;
          erase_ok_d = 1'b1;
        end
      end
      ACT_BEGIN: cur_d = '0;
      ACT_END:   cur_d = (count_q == '0) ? '0 : count_q - ONE;
      ACT_PREV: begin
        if (cursor_q != '0) begin
          cur_d = cursor_q - ONE;
        end
      end
      ACT_NEXT: begin
        if ((count_q != '0) && (cursor_q < count_q - ONE)) begin
          cur_d = cursor_q + ONE;
        end
      end
      ACT_SETPOS: begin
        if (in_target > count_q) begin
          st_d = ST_RANGE;
        end else begin
          cur_d = in_target;
        end
      end
      ACT_FIND: find_d = 1'b1;
      ACT_CLEAR: begin
        cnt_d = '0;
        cur_d = '0;
      end
      default: ;
    endcase
    rd_en_d = erase_ok_d || ((cur_d < count_q) && (cur_d < cnt_d));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_SCAN;
      S_SCAN: if (probe[CAPACITY].active) state_d = S_DONE;
      S_DONE: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      cursor_q   <= '0;
      start_q    <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept;
      if (commit) begin
        count_q    <= cnt_nx_q;
        cursor_q   <= cur_nx_q;
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cnt_nx_q <= cnt_d;
      cur_nx_q <= cur_d;
      st_q     <= st_d;
      kind_q   <= kind_d;
      at_q     <= at_d;
      find_q   <= find_d;
      ovr_q    <= ovr_d;
      rd_en_q  <= rd_en_d;
      val_q    <= in_val;
    end
    if (probe[CAPACITY].active) begin
      res_found_q <= probe[CAPACITY].found;
      res_idx_q   <= pidx[CAPACITY];
      res_val_q   <= pval[CAPACITY];
    end
    if (commit) begin
      out_val_q   <= ovr_q ? val_q : (rd_en_q ? res_val_q : '0);
      out_size_q  <= cnt_nx_q;
      out_cur_q   <= cur_nx_q;
      out_found_q <= res_found_q;
      out_idx_q   <= res_idx_q;
      out_st_q    <= st_q;
    end
  end

  assign ctrl.kind    = commit ? kind_q : UPD_NONE;
  assign ctrl.find_en = find_q;

  assign probe[0].active = start_q;
  assign probe[0].found  = 1'b0;
  assign pval[0]         = '0;
  assign pidx[0]         = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_w[g] = val_q;
    end else begin : g_mid_l
      assign left_w[g] = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w[g] = entry[g];
    end else begin : g_mid_r
      assign right_w[g] = entry[g+1];
    end

    alc_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CNT_W),
      .IDX_W     (IDX_W),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .upd_at_i   (at_q),
      .upd_val_i  (val_q),
      .left_i     (left_w[g]),
      .right_i    (right_w[g]),
      .key_i      (val_q),
      .rd_pos_i   (cur_nx_q),
      .cnt_i      (count_q),
      .probe_i    (probe[g]),
      .probe_val_i(pval[g]),
      .probe_idx_i(pidx[g]),
      .entry_o    (entry[g]),
      .probe_o    (probe[g+1]),
      .probe_val_o(pval[g+1]),
      .probe_idx_o(pidx[g+1])
    );
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = OUT_TW'({out_st_q, out_idx_q, out_found_q,
                                  out_cur_q, out_size_q, out_val_q});

  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q) else $error("cursor beyond list size");

  a_size_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT) else $error("list size beyond capacity");

  a_probe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe[CAPACITY].active |-> state_q == S_SCAN) else $error("probe outside scan");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && out_st_q == ST_FULL) |-> out_size_q == CAP_CNT)
    else $error("full status with room left");

endmodule
